[rtl/core/alc_pkg.sv]
// ----------------------------------------------------------------------------
// alc_pkg: shared types and constants of the lux calculator
// Field widths, register map, clipping limits, scale factors and the
// piecewise-linear segment tables of both sensor packages.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int CountW = 16;
  localparam int LuxW   = 18;
  localparam int NormW  = 22;   // normalized count width
  localparam int FactW  = 19;   // scale factor width
  localparam int QuoW   = 11;   // truncated quotient width
  localparam int CoefW  = 10;   // breakpoint and coefficient width
  localparam int ProdW  = 32;   // segment product width
  localparam int DivStages = 6; // two quotient bits per stage, one in the last
  localparam int DivSteps  = 11;

  localparam logic [1:0] REG_INTEG   = 2'd0;
  localparam logic [1:0] REG_GAIN    = 2'd1;
  localparam logic [1:0] REG_PACKAGE = 2'd2;

  localparam logic [1:0] INTEG_13MS  = 2'd0;
  localparam logic [1:0] INTEG_101MS = 2'd1;

  localparam logic [CountW-1:0] CLIP_13MS  = 16'd4900;
  localparam logic [CountW-1:0] CLIP_101MS = 16'd37000;
  localparam logic [CountW-1:0] CLIP_402MS = 16'd65000;

  localparam logic [FactW-1:0] SCALE_13MS  = 19'h07517;
  localparam logic [FactW-1:0] SCALE_101MS = 19'h00FE7;
  localparam logic [FactW-1:0] SCALE_402MS = 19'h00400;

  localparam logic [CoefW-1:0] SEG_BP [2][8] = '{
    '{10'h040, 10'h080, 10'h0C0, 10'h100, 10'h138, 10'h19A, 10'h29A, 10'h29A},
    '{10'h043, 10'h085, 10'h0C8, 10'h10A, 10'h14D, 10'h19A, 10'h29A, 10'h29A}
  };
  localparam logic [CoefW-1:0] SEG_B [2][8] = '{
    '{10'h1F2, 10'h214, 10'h23F, 10'h270, 10'h16F, 10'h0D2, 10'h018, 10'h000},
    '{10'h204, 10'h228, 10'h253, 10'h282, 10'h177, 10'h101, 10'h037, 10'h000}
  };
  localparam logic [CoefW-1:0] SEG_M [2][8] = '{
    '{10'h1BE, 10'h2D1, 10'h37B, 10'h3FE, 10'h1FC, 10'h0FB, 10'h012, 10'h000},
    '{10'h1AD, 10'h2C1, 10'h363, 10'h3DF, 10'h1DD, 10'h127, 10'h02B, 10'h000}
  };

  typedef struct packed {
    logic             clip;
    logic             zero;
    logic             over;
    logic [NormW-1:0] bbn;
    logic [NormW-1:0] irn;
    logic [NormW-1:0] rem;
    logic [QuoW-1:0]  quo;
  } alc_div_t;

  typedef struct packed {
    logic [NormW-1:0] rem;
    logic             qbit;
  } alc_step_t;

  function automatic logic [CountW-1:0] clip_limit(logic [1:0] code);
    logic [CountW-1:0] lim;
    case (code)
      INTEG_13MS:  lim = CLIP_13MS;
      INTEG_101MS: lim = CLIP_101MS;
      default:     lim = CLIP_402MS;
    endcase
    return lim;
  endfunction

  function automatic logic [FactW-1:0] norm_factor(logic [1:0] code, logic hg);
    logic [FactW-1:0] f;
    case (code)
      INTEG_13MS:  f = SCALE_13MS;
      INTEG_101MS: f = SCALE_101MS;
      default:     f = SCALE_402MS;
    endcase
    if (!hg) begin
      f = {f[FactW-5:0], 4'b0000};
    end
    return f;
  endfunction

  // One restoring division step: shift in a bit, subtract when it fits.
  function automatic alc_step_t div_step(logic [NormW-1:0] rem, logic [NormW-1:0] dvs,
                                          logic bin);
    logic [NormW:0] t;
    alc_step_t      r;
    t = {rem, bin};
    if (t >= {1'b0, dvs}) begin
      t      = t - {1'b0, dvs};
      r.qbit = 1'b1;
    end else begin
      r.qbit = 1'b0;
    end
    r.rem = t[NormW-1:0];
    return r;
  endfunction

endpackage

[rtl/core/alc_in_if.sv]
// ----------------------------------------------------------------------------
// alc_in_if: sample pair channel
// Valid/ready channel carrying one broadband and one infrared count.
// ----------------------------------------------------------------------------
interface alc_in_if;
  logic                       valid;
  logic                       ready;
  logic [alc_pkg::CountW-1:0] broadband_count;
  logic [alc_pkg::CountW-1:0] infrared_count;

  modport source (output valid, output broadband_count, output infrared_count,
                  input ready);
  modport sink   (input valid, input broadband_count, input infrared_count,
                  output ready);
endinterface

[rtl/core/alc_out_if.sv]
// ----------------------------------------------------------------------------
// alc_out_if: lux result channel
// Valid/ready channel carrying the lux value and the clipped flag.
// ----------------------------------------------------------------------------
interface alc_out_if;
  logic                     valid;
  logic                     ready;
  logic [alc_pkg::LuxW-1:0] lux_value;
  logic                     clipped;

  modport source (output valid, output lux_value, output clipped, input ready);
  modport sink   (input valid, input lux_value, input clipped, output ready);
endinterface

[rtl/core/ambient_light_lux_calc.sv]
// ----------------------------------------------------------------------------
// ambient_light_lux_calc: two-channel photodiode lux calculator
// Clip check, count normalization, IR/broadband ratio, segment lookup and
// piecewise-linear lux evaluation in an eleven-stage pipeline.
// ----------------------------------------------------------------------------
// The block takes one sample request (broadband and infrared count) per clock
// and returns one result request per sample, in order, from the output
// register of the last stage. Throughput is one sample per cycle; a
// stall on the result side freezes the whole pipeline, so nothing is lost or
// repeated. Most of the pipeline is the ratio divider, which resolves
// the eleven quotient bits two per stage over its six stages (the last stage
// resolves one). Configuration (integration
// time, gain, package table) is written over the APB port at byte addresses
// 0, 4 and 8 and must only change while no sample is in flight.
// ----------------------------------------------------------------------------
module ambient_light_lux_calc (
  input  logic        clk_i,
  input  logic        rst_ni,
  alc_in_if.sink      sample_i,
  alc_out_if.source   result_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [1:0] integ_q;
  logic       gain_q;
  logic       pkg_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= 2'd0;
      gain_q  <= 1'b0;
      pkg_q   <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        alc_pkg::REG_INTEG:   integ_q <= pwdata[1:0];
        alc_pkg::REG_GAIN:    gain_q  <= pwdata[0];
        alc_pkg::REG_PACKAGE: pkg_q   <= pwdata[0];
        default: ;  // drop writes outside the register map
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      alc_pkg::REG_INTEG:   prdata = {30'd0, integ_q};
      alc_pkg::REG_GAIN:    prdata = {31'd0, gain_q};
      alc_pkg::REG_PACKAGE: prdata = {31'd0, pkg_q};
      default:              prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves together unless the output is stuck
  // --------------------------------------------------------------------------
  logic adv;
  logic vld_out_q;

  assign adv            = !vld_out_q || result_o.ready;
  assign sample_i.ready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: clip check and normalization to 402 ms / 16x, scale factors in 2^-10 units
  // --------------------------------------------------------------------------
  logic [alc_pkg::CountW-1:0] lim;
  logic [alc_pkg::FactW-1:0]  fact;
  logic [34:0]                bb_prod;
  logic [34:0]                ir_prod;
  logic                       vld1_q;
  logic                       clip1_q;
  logic [alc_pkg::NormW-1:0]  bbn1_q;
  logic [alc_pkg::NormW-1:0]  irn1_q;

  assign lim     = alc_pkg::clip_limit(integ_q);
  assign fact    = alc_pkg::norm_factor(integ_q, gain_q);
  assign bb_prod = {19'd0, sample_i.broadband_count} * {16'd0, fact};
  assign ir_prod = {19'd0, sample_i.infrared_count} * {16'd0, fact};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= sample_i.valid;
    end
  end

  // An unclipped count keeps the product below 2^32, so bits above 31 drop.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip1_q <= (sample_i.broadband_count > lim) || (sample_i.infrared_count > lim);
      bbn1_q  <= bb_prod[31:10];
      irn1_q  <= ir_prod[31:10];
    end
  end

  // --------------------------------------------------------------------------
  // Stages 2-7: ratio divider (irn << 10) / bbn
  // Only quotients below 2048 matter; larger ones are flagged as over and
  // take the last segment. The numerator low bits are zero except irn[0].
  // --------------------------------------------------------------------------
  alc_pkg::alc_div_t div_in [alc_pkg::DivStages];
  alc_pkg::alc_div_t div_d  [alc_pkg::DivStages];
  alc_pkg::alc_div_t div_q  [alc_pkg::DivStages];
  logic [alc_pkg::DivStages-1:0] vld_div_q;

  always_comb begin
    div_in[0].clip = clip1_q;
    div_in[0].zero = (bbn1_q == '0);
    div_in[0].over = ({1'b0, irn1_q} >= {bbn1_q, 1'b0});
    div_in[0].bbn  = bbn1_q;
    div_in[0].irn  = irn1_q;
    div_in[0].rem  = {1'b0, irn1_q[alc_pkg::NormW-1:1]};
    div_in[0].quo  = '0;
    for (int s = 1; s < alc_pkg::DivStages; s++) begin
      div_in[s] = div_q[s-1];
    end
  end

  always_comb begin
    alc_pkg::alc_step_t st;
    logic               bin;
    for (int s = 0; s < alc_pkg::DivStages; s++) begin
      div_d[s] = div_in[s];
      for (int j = 0; j < 2; j++) begin
        if (2 * s + j < alc_pkg::DivSteps) begin
          bin = (2 * s + j == 0) ? div_in[s].irn[0] : 1'b0;
          st  = alc_pkg::div_step(div_d[s].rem, div_d[s].bbn, bin);
          div_d[s].rem = st.rem;
          div_d[s].quo = {div_d[s].quo[alc_pkg::QuoW-2:0], st.qbit};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_div_q <= '0;
    end else if (adv) begin
      vld_div_q <= {vld_div_q[alc_pkg::DivStages-2:0], vld1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < alc_pkg::DivStages; s++) begin
        div_q[s] <= div_d[s];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 8: round the ratio to 2^-9 units and pick the segment
  // --------------------------------------------------------------------------
  alc_pkg::alc_div_t          div_last;
  logic [alc_pkg::QuoW:0]     rnd_sum;
  logic [alc_pkg::QuoW-1:0]   ratio;
  logic [2:0]                 seg;
  logic                       vld_seg_q;
  logic                       clip_seg_q;
  logic [alc_pkg::NormW-1:0]  bbn_seg_q;
  logic [alc_pkg::NormW-1:0]  irn_seg_q;
  logic [alc_pkg::CoefW-1:0]  b_seg_q;
  logic [alc_pkg::CoefW-1:0]  m_seg_q;

  assign div_last = div_q[alc_pkg::DivStages-1];
  assign rnd_sum  = {1'b0, div_last.quo} + {{alc_pkg::QuoW{1'b0}}, 1'b1};
  assign ratio    = rnd_sum[alc_pkg::QuoW:1];

  always_comb begin
    seg = 3'd7;
    // Scan from the top so the lowest matching breakpoint wins.
    for (int i = 6; i >= 0; i--) begin
      if (ratio <= {1'b0, alc_pkg::SEG_BP[pkg_q][i]}) begin
        seg = 3'(i);
      end
    end
    if (div_last.zero) begin
      seg = 3'd0;
    end else if (div_last.over) begin
      seg = 3'd7;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_seg_q <= 1'b0;
    end else if (adv) begin
      vld_seg_q <= vld_div_q[alc_pkg::DivStages-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip_seg_q <= div_last.clip;
      bbn_seg_q  <= div_last.bbn;
      irn_seg_q  <= div_last.irn;
      b_seg_q    <= alc_pkg::SEG_B[pkg_q][seg];
      m_seg_q    <= alc_pkg::SEG_M[pkg_q][seg];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 9: offset and slope products
  // --------------------------------------------------------------------------
  logic                      vld_mul_q;
  logic                      clip_mul_q;
  logic [alc_pkg::ProdW-1:0] pos_q;
  logic [alc_pkg::ProdW-1:0] neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_mul_q <= 1'b0;
    end else if (adv) begin
      vld_mul_q <= vld_seg_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip_mul_q <= clip_seg_q;
      pos_q      <= {10'd0, bbn_seg_q} * {22'd0, b_seg_q};
      neg_q      <= {10'd0, irn_seg_q} * {22'd0, m_seg_q};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 10: difference clamped at zero
  // --------------------------------------------------------------------------
  logic                      vld_dif_q;
  logic                      clip_dif_q;
  logic [alc_pkg::ProdW-1:0] acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_dif_q <= 1'b0;
    end else if (adv) begin
      vld_dif_q <= vld_mul_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clip_dif_q <= clip_mul_q;
      acc_q      <= (pos_q > neg_q) ? (pos_q - neg_q) : '0;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 11: round by 2^14, saturate, zero clipped samples; output register
  // --------------------------------------------------------------------------
  logic [alc_pkg::ProdW:0]  acc_rnd;
  logic [alc_pkg::LuxW:0]   lux_sh;
  logic [alc_pkg::LuxW-1:0] lux_d;
  logic [alc_pkg::LuxW-1:0] lux_q;
  logic                     clip_q;

  assign acc_rnd = {1'b0, acc_q} + 33'd8192;
  assign lux_sh  = acc_rnd[alc_pkg::ProdW:14];

  always_comb begin
    if (clip_dif_q) begin
      lux_d = '0;
    end else if (lux_sh[alc_pkg::LuxW]) begin
      lux_d = '1;
    end else begin
      lux_d = lux_sh[alc_pkg::LuxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else if (adv) begin
      vld_out_q <= vld_dif_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      lux_q  <= lux_d;
      clip_q <= clip_dif_q;
    end
  end

  assign result_o.valid     = vld_out_q;
  assign result_o.lux_value = lux_q;
  assign result_o.clipped   = clip_q;

`ifndef NO_ASSERTIONS
  // A clipped result always reports zero lux.
  a_clip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_out_q && clip_q |-> lux_q == '0)
    else $error("clipped result with nonzero lux");

  // The divider remainder stays below the divisor for in-range ratios.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_div_q[alc_pkg::DivStages-1] && !div_last.over |-> div_last.rem < div_last.bbn)
    else $error("divider remainder out of range");

  // A zero offset only comes from the last segment, which also has zero slope.
  a_seg_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_seg_q && b_seg_q == '0 |-> m_seg_q == '0)
    else $error("segment offset and slope mismatch");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the ambient light lux calculator
// Drives sample pairs over the valid/ready channel with random idling on
// both sides. Predicts each result from the sample and the register settings
// the bench has written, and compares the results in order. Sweeps every
// integration time, gain and package setting.
// ----------------------------------------------------------------------------
module testbench;

  localparam int PIPE_DEPTH  = 11;
  localparam int CYCLE_LIMIT = 300000;
  localparam int RANDOM_SETS = 16;
  localparam int SET_SAMPLES = 82;

  // Integration codes past 101 ms and the unmapped register slot.
  localparam logic [1:0] INTEG_402MS     = 2'd2;
  localparam logic [1:0] INTEG_402MS_ALT = 2'd3;
  localparam logic [1:0] REG_SPARE       = 2'd3;

  localparam longint unsigned LUX_CEIL = 262143;

  // Segment tables: breakpoint, offset and slope per package.
  localparam longint unsigned BREAK_PT [2][8] = '{
    '{'h040, 'h080, 'h0C0, 'h100, 'h138, 'h19A, 'h29A, 'h29A},
    '{'h043, 'h085, 'h0C8, 'h10A, 'h14D, 'h19A, 'h29A, 'h29A}
  };
  localparam longint unsigned OFFSET_B [2][8] = '{
    '{'h1F2, 'h214, 'h23F, 'h270, 'h16F, 'h0D2, 'h018, 'h000},
    '{'h204, 'h228, 'h253, 'h282, 'h177, 'h101, 'h037, 'h000}
  };
  localparam longint unsigned SLOPE_M [2][8] = '{
    '{'h1BE, 'h2D1, 'h37B, 'h3FE, 'h1FC, 'h0FB, 'h012, 'h000},
    '{'h1AD, 'h2C1, 'h363, 'h3DF, 'h1DD, 'h127, 'h02B, 'h000}
  };

  typedef struct {
    logic [alc_pkg::LuxW-1:0] lux;
    logic                     clipped;
  } lux_result_t;

  class lux_scoreboard;
    logic [1:0]  integ_code;
    logic        high_gain;
    logic        pkg_cs;
    lux_result_t pending_lux[$];
    int          mismatch_count;

    function new();
      integ_code     = alc_pkg::INTEG_13MS;
      high_gain      = 1'b0;
      pkg_cs         = 1'b0;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        alc_pkg::REG_INTEG:   integ_code = value[1:0];
        alc_pkg::REG_GAIN:    high_gain  = value[0];
        alc_pkg::REG_PACKAGE: pkg_cs     = value[0];
        default: ;
      endcase
    endfunction

    function int unsigned count_limit();
      case (integ_code)
        alc_pkg::INTEG_13MS:  return 4900;
        alc_pkg::INTEG_101MS: return 37000;
        default:              return 65000;
      endcase
    endfunction

    function int pending();
      return pending_lux.size();
    endfunction

    function lux_result_t predict_lux(logic [alc_pkg::CountW-1:0] bb,
                                      logic [alc_pkg::CountW-1:0] ir);
      lux_result_t     res;
      longint unsigned scale, bbn, irn, ratio, pos, neg, acc;
      int              seg;
      res.lux     = '0;
      res.clipped = 1'b0;
      if (bb > count_limit() || ir > count_limit()) begin
        res.clipped = 1'b1;
        return res;
      end
      case (integ_code)
        alc_pkg::INTEG_13MS:  scale = 'h7517;
        alc_pkg::INTEG_101MS: scale = 'h0FE7;
        default:              scale = 1024;
      endcase
      if (!high_gain) begin
        scale = scale << 4;
      end
      bbn = (longint'(bb) * scale) >> 10;
      irn = (longint'(ir) * scale) >> 10;
      // Ratio in 2^-9 units, rounded; a zero broadband picks the first segment.
      ratio = 0;
      if (bbn != 0) begin
        ratio = (irn << 10) / bbn;
      end
      ratio = (ratio + 1) >> 1;
      seg = 7;
      for (int i = 6; i >= 0; i--) begin
        if (ratio <= BREAK_PT[pkg_cs][i]) begin
          seg = i;
        end
      end
      pos = bbn * OFFSET_B[pkg_cs][seg];
      neg = irn * SLOPE_M[pkg_cs][seg];
      acc = (pos > neg) ? (pos - neg) : 0;
      acc = (acc + 8192) >> 14;
      if (acc > LUX_CEIL) begin
        acc = LUX_CEIL;
      end
      res.lux = acc[alc_pkg::LuxW-1:0];
      return res;
    endfunction

    function void note_sample(logic [alc_pkg::CountW-1:0] bb,
                              logic [alc_pkg::CountW-1:0] ir);
      pending_lux.push_back(predict_lux(bb, ir));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
    endtask

    task check_result(logic [alc_pkg::LuxW-1:0] lux, logic clipped);
      lux_result_t want;
      if (pending_lux.size() == 0) begin
        report_mismatch($sformatf("result lux=%0d clipped=%0b with no sample pending",
                                  lux, clipped));
        return;
      end
      want = pending_lux.pop_front();
      if (lux !== want.lux) begin
        report_mismatch($sformatf("lux_value got %0d want %0d", lux, want.lux));
      end
      if (clipped !== want.clipped) begin
        report_mismatch($sformatf("clipped got %0b want %0b", clipped, want.clipped));
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  alc_in_if  sample_if ();
  alc_out_if result_if ();

  lux_scoreboard sb;
  int            send_idle_pct;
  int            recv_idle_pct;
  int            cycle_count;

  ambient_light_lux_calc dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Offer one sample request; hold it until the block takes it.
  task automatic send_sample(logic [alc_pkg::CountW-1:0] bb,
                             logic [alc_pkg::CountW-1:0] ir);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid           <= 1'b1;
    sample_if.broadband_count <= bb;
    sample_if.infrared_count  <= ir;
    @(posedge clk_i);
    while (!sample_if.ready) begin
      @(posedge clk_i);
    end
    sb.note_sample(bb, ir);
  endtask

  // Mostly in-range pairs with spread ratios, some near the clip limit,
  // some raw 16-bit noise.
  task automatic send_random_sample();
    int unsigned lim, bb, ir, pick;
    lim  = sb.count_limit();
    pick = $urandom_range(99);
    if (pick < 8) begin
      bb = $urandom_range(65535);
      ir = $urandom_range(65535);
    end else if (pick < 13) begin
      bb = lim - 2 + $urandom_range(4);
      ir = $urandom_range(lim + 2);
    end else if (pick < 18) begin
      bb = $urandom_range(lim);
      ir = lim - 2 + $urandom_range(4);
    end else begin
      bb = (pick < 35) ? $urandom_range(40) : $urandom_range(lim);
      ir = (bb * $urandom_range(1450)) >> 10;
    end
    if (ir > 65535) begin
      ir = 65535;
    end
    send_sample(bb[alc_pkg::CountW-1:0], ir[alc_pkg::CountW-1:0]);
  endtask

  // Drop valid and hold until every pending result is back and the pipe is empty.
  task automatic wait_drain();
    sample_if.valid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  // Setup then access phase; the register takes the value at the access edge.
  task automatic apb_write(logic [1:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    sb.set_register(idx, value);
  endtask

  // Reprogram all registers once the block is idle; upper data bits are junk.
  task automatic apply_settings(logic [1:0] code, logic hg, logic pk);
    logic [31:0] value;
    wait_drain();
    value      = $urandom;
    value[1:0] = code;
    apb_write(alc_pkg::REG_INTEG, value);
    value    = $urandom;
    value[0] = hg;
    apb_write(alc_pkg::REG_GAIN, value);
    value    = $urandom;
    value[0] = pk;
    apb_write(alc_pkg::REG_PACKAGE, value);
    if ($urandom_range(3) == 0) begin
      apb_write(REG_SPARE, $urandom);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Result side: check every accepted request, then pick the next ready.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_if.valid && result_if.ready) begin
        sb.check_result(result_if.lux_value, result_if.clipped);
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    sb            = new();
    send_idle_pct = 27;
    recv_idle_pct = 69;
    sample_if.valid           <= 1'b0;
    sample_if.broadband_count <= '0;
    sample_if.infrared_count  <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    rst_ni  <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // 13 ms, 1x, standard package: clip boundary, zero broadband, steep ratio.
    apply_settings(alc_pkg::INTEG_13MS, 1'b0, 1'b0);
    send_sample(16'd0, 16'd0);
    send_sample(16'd4900, 16'd4900);
    send_sample(16'd4901, 16'd0);
    send_sample(16'd0, 16'd4901);
    send_sample(16'd65535, 16'd65535);
    send_sample(16'd4900, 16'd0);
    send_sample(16'd0, 16'd4900);
    send_sample(16'd1000, 16'd1400);
    send_sample(16'd1000, 16'd100);

    // 402 ms, 16x: full-scale counts and the smallest nonzero broadband.
    apply_settings(INTEG_402MS, 1'b1, 1'b0);
    send_sample(16'd65000, 16'd0);
    send_sample(16'd65000, 16'd65000);
    send_sample(16'd65001, 16'd0);
    send_sample(16'd1, 16'd0);
    send_sample(16'd3000, 16'd300);
    send_sample(16'd3000, 16'd1500);
    send_sample(16'd40000, 16'd39000);

    // Code 3 on the CS table: the last live segment goes negative here.
    apply_settings(INTEG_402MS_ALT, 1'b0, 1'b1);
    send_sample(16'd1000, 16'd1300);
    send_sample(16'd65000, 16'd100);
    send_sample(16'd65535, 16'd0);
    send_sample(16'd0, 16'd65000);

    apply_settings(alc_pkg::INTEG_101MS, 1'b1, 1'b1);
    send_sample(16'd37000, 16'd37000);
    send_sample(16'd37001, 16'd5);
    send_sample(16'd37000, 16'd0);

    // Random sets over every register combination; swap the idling, then drop it.
    for (int set = 0; set < RANDOM_SETS; set++) begin
      if (set == 6) begin
        send_idle_pct = 69;
        recv_idle_pct = 27;
      end else if (set == 11) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_settings(set[1:0], set[2], set[3]);
      for (int n = 0; n < SET_SAMPLES; n++) begin
        send_random_sample();
        if (set == 4 && n == SET_SAMPLES / 2) begin
          wait_drain();
        end
      end
    end

    wait_drain();
    if (sb.mismatch_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
